@@ src/hes_pkg.sv @@
// ----------------------------------------------------------------------------
// hes_pkg: shared types and constants for histogram_entropy_stats
// Field widths, datapath widths, controller command and status records.
// ----------------------------------------------------------------------------
package hes_pkg;

  // default parameter values
  localparam int HES_VALUE_BITS       = 16;
  localparam int HES_BIN_COUNT_BITS   = 24;
  localparam int HES_TOTAL_COUNT_BITS = 32;

  // interface field widths
  localparam int IDX_W  = 17;
  localparam int CNT_W  = 24;
  localparam int SYM_W  = 32;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 39;
  localparam int ENT_W  = 22;
  localparam int BITS_W = 38;
  localparam int CFG_W  = 16;

  // datapath widths
  localparam int LOG_W  = 21;   // log2 in Q16, integer part up to 31
  localparam int WSUM_W = 49;   // signed sum of count*index
  localparam int QSUM_W = 64;   // sum of count*index^2
  localparam int LSUM_W = 54;   // sum of count*log2(count)
  localparam int ACC_W  = 96;   // Q*N - W^2
  localparam int DIV_NW = 105;  // dividend width, (Q*N - W^2) << 9
  localparam int DIV_DW = 64;   // divisor width, N^2

  typedef enum logic [1:0] {
    REG_VALUE_LOW  = 2'd0,
    REG_VALUE_HIGH = 2'd1,
    REG_MAX_RUN    = 2'd2
  } cfg_reg_t;

  // shared multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_MAG_MAG,
    MUL_CNT_P,
    MUL_CNT_MAG,
    MUL_CNT_LOG,
    MUL_N_N,
    MUL_QLO_N,
    MUL_QHI_N,
    MUL_WL_WL,
    MUL_WL_WH,
    MUL_WH_WH,
    MUL_ENT_T
  } mul_op_t;

  // running sum that takes the registered product
  typedef enum logic [1:0] {
    SUM_NONE,
    SUM_Q,
    SUM_W,
    SUM_L
  } sum_op_t;

  // variance numerator accumulator
  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_CLR,
    ACC_ADD0,
    ACC_ADD32,
    ACC_SUB0,
    ACC_SUB33,
    ACC_SUB64
  } acc_op_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_MEAN,
    DIV_VAR,
    DIV_ENT
  } div_op_t;

  typedef struct packed {
    logic    take;        // latch input item
    logic    commit;      // count, prefix, min/max update
    logic    sat;         // saturate total count
    mul_op_t mul;
    sum_op_t sum;
    acc_op_t acc;
    logic    log_start;
    logic    log_tot;     // log operand is total count, else bin count
    logic    fin_n;       // latch symbol count
    div_op_t div;
    logic    nn_cap;
    logic    mean_cap;
    logic    var_cap;
    logic    ent_cap;
    logic    bits_cap;
    logic    load;        // result to output register, clear histogram
  } hes_cmd_t;

  typedef struct packed {
    logic ok;
    logic sat;
    logic last;
    logic n_zero;
    logic log_busy;
    logic div_busy;
    logic out_free;
  } hes_sts_t;

endpackage

@@ src/hes_if.sv @@
// ----------------------------------------------------------------------------
// hes_in_if / hes_out_if: valid/ready channels of histogram_entropy_stats
// Bin channel and result channel with source and sink modports.
// ----------------------------------------------------------------------------
interface hes_in_if;
  import hes_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] bin_index;
  logic [CNT_W-1:0] bin_count;
  logic             last_bin;

  modport source (output valid, mode, bin_index, bin_count, last_bin, input ready);
  modport sink   (input valid, mode, bin_index, bin_count, last_bin, output ready);
endinterface

interface hes_out_if;
  import hes_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  min_seen;
  logic [IDX_W-1:0]  max_seen;
  logic [SYM_W-1:0]  symbol_count;
  logic [MEAN_W-1:0] mean_q8;
  logic [VAR_W-1:0]  variance_q8;
  logic [ENT_W-1:0]  entropy_q16;
  logic [BITS_W-1:0] total_bits;
  logic              count_overflow;

  modport source (output valid, min_seen, max_seen, symbol_count, mean_q8, variance_q8,
                  entropy_q16, total_bits, count_overflow, input ready);
  modport sink   (input valid, min_seen, max_seen, symbol_count, mean_q8, variance_q8,
                  entropy_q16, total_bits, count_overflow, output ready);
endinterface

@@ src/hes_log.sv @@
// ----------------------------------------------------------------------------
// hes_log: iterative log2 in Q16
// Normalizes one bit per cycle, then 16 truncated squarings of a Q30 mantissa.
// ----------------------------------------------------------------------------
module hes_log (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               operand,
  output logic                      busy,
  output logic [hes_pkg::LOG_W-1:0] result
);
  import hes_pkg::*;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ
  } lg_state_t;

  lg_state_t   state_r;
  logic [31:0] m_r;
  logic [4:0]  e_r;
  logic [15:0] frac_r;
  logic [3:0]  step_r;
  logic [63:0] sq;
  logic [31:0] sq_q30;

  assign sq     = m_r * m_r;
  assign sq_q30 = sq[61:30];
  assign busy   = (state_r != LG_IDLE);
  assign result = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
    end else begin
      unique case (state_r)
        LG_IDLE: begin
          if (start) begin
            state_r <= (operand == 32'd0) ? LG_IDLE : LG_NORM;
          end
        end
        LG_NORM: begin
          if (m_r[31]) begin
            state_r <= LG_SQ;
          end
        end
        LG_SQ: begin
          if (step_r == 4'd0) begin
            state_r <= LG_IDLE;
          end
        end
        default: state_r <= LG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      LG_IDLE: begin
        if (start) begin
          m_r    <= operand;
          e_r    <= 5'd31;
          frac_r <= '0;
          step_r <= 4'd15;
          if (operand == 32'd0) begin
            e_r <= 5'd0;
          end
        end
      end
      LG_NORM: begin
        if (m_r[31]) begin
          m_r <= {1'b0, m_r[31:1]};   // Q30 mantissa in [1,2)
        end else begin
          m_r <= {m_r[30:0], 1'b0};
          e_r <= e_r - 5'd1;
        end
      end
      LG_SQ: begin
        step_r <= step_r - 4'd1;
        if (sq_q30[31]) begin
          m_r    <= {1'b0, sq_q30[31:1]};
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= sq_q30;
          frac_r <= {frac_r[14:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/hes_div.sv @@
// ----------------------------------------------------------------------------
// hes_div: restoring divider, one quotient bit per cycle
// Quotient shifts in where the dividend shifts out.
// ----------------------------------------------------------------------------
module hes_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hes_pkg::DIV_NW-1:0] num,
  input  logic [hes_pkg::DIV_DW-1:0] den,
  output logic                       busy,
  output logic [hes_pkg::DIV_NW-1:0] quo
);
  import hes_pkg::*;

  localparam int STEP_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              fits;

  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});
  assign busy  = busy_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == STEP_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      den_r  <= den;
      quo_r  <= num;
      step_r <= STEP_W'(DIV_NW);
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_r  <= {quo_r[DIV_NW-2:0], fits};
      step_r <= step_r - STEP_W'(1);
    end
  end

endmodule

@@ src/hes_dp.sv @@
// ----------------------------------------------------------------------------
// hes_dp: histogram statistics datapath
// Item latch, running sums, shared 32x32 multiplier, log and divide units,
// result register.
// ----------------------------------------------------------------------------
module hes_dp #(
  parameter int VALUE_BITS       = hes_pkg::HES_VALUE_BITS,
  parameter int BIN_COUNT_BITS   = hes_pkg::HES_BIN_COUNT_BITS,
  parameter int TOTAL_COUNT_BITS = hes_pkg::HES_TOTAL_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hes_pkg::hes_cmd_t          cmd,
  output hes_pkg::hes_sts_t          sts,
  input  logic [hes_pkg::CFG_W-1:0]  cfg_low,
  input  logic [hes_pkg::CFG_W-1:0]  cfg_high,
  input  logic [hes_pkg::CFG_W-1:0]  cfg_run,
  input  logic                       in_mode,
  input  logic [hes_pkg::IDX_W-1:0]  in_bin_index,
  input  logic [hes_pkg::CNT_W-1:0]  in_bin_count,
  input  logic                       in_last_bin,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [hes_pkg::IDX_W-1:0]  out_min_seen,
  output logic [hes_pkg::IDX_W-1:0]  out_max_seen,
  output logic [hes_pkg::SYM_W-1:0]  out_symbol_count,
  output logic [hes_pkg::MEAN_W-1:0] out_mean_q8,
  output logic [hes_pkg::VAR_W-1:0]  out_variance_q8,
  output logic [hes_pkg::ENT_W-1:0]  out_entropy_q16,
  output logic [hes_pkg::BITS_W-1:0] out_total_bits,
  output logic                       out_count_overflow
);
  import hes_pkg::*;

  localparam int TCB = TOTAL_COUNT_BITS;
  localparam logic signed [17:0] VMIN   = 18'(-(2 ** (VALUE_BITS - 1)));
  localparam logic signed [17:0] VMAX   = 18'(2 ** (VALUE_BITS - 1) - 1);
  localparam logic signed [17:0] RUNMAX = 18'(2 ** VALUE_BITS - 1);
  localparam logic [32:0]        TMAX   = 33'((64'd1 << TCB) - 64'd1);

  // item
  logic                      mode_r;
  logic [IDX_W-1:0]          idx_r;
  logic [BIN_COUNT_BITS-1:0] cnt_r;
  logic                      last_r;

  // histogram state
  logic [TCB-1:0]            tot_r;
  logic [TCB-1:0]            pre_r;
  logic signed [WSUM_W-1:0]  w_r;
  logic [QSUM_W-1:0]         q_r;
  logic [LSUM_W-1:0]         l_r;
  logic [IDX_W-1:0]          min_r;
  logic [IDX_W-1:0]          max_r;
  logic                      any_r;
  logic                      ovf_r;

  // final phase
  logic [63:0]               p_r;
  logic [ACC_W-1:0]          acc_r;
  logic [SYM_W-1:0]          n_r;
  logic [63:0]               nn_r;
  logic [MEAN_W-1:0]         mean_r;
  logic [VAR_W-1:0]          var_r;
  logic [LOG_W-1:0]          ent_r;
  logic [BITS_W-1:0]         bits_r;
  logic                      out_valid_r;

  // range and saturation checks
  logic signed [17:0] idx_s, lo_s, hi_s, low_s, high_s, run_s, top_s;
  logic               ok_val, ok_run;
  logic [32:0]        sum33;
  logic [31:0]        tot32;
  logic [16:0]        mag;

  assign idx_s  = {idx_r[IDX_W-1], idx_r};
  assign low_s  = {{2{cfg_low[CFG_W-1]}}, cfg_low};
  assign high_s = {{2{cfg_high[CFG_W-1]}}, cfg_high};
  assign run_s  = {2'b00, cfg_run};
  assign lo_s   = (low_s > VMIN) ? low_s : VMIN;
  assign hi_s   = (high_s < VMAX) ? high_s : VMAX;
  assign top_s  = (run_s < RUNMAX) ? run_s : RUNMAX;
  assign ok_val = (idx_s >= lo_s) && (idx_s <= hi_s);
  assign ok_run = (idx_s >= 18'sd1) && (idx_s <= top_s);
  assign sum33  = 33'(tot_r) + 33'(cnt_r);
  assign tot32  = 32'(tot_r);
  assign mag    = idx_r[IDX_W-1] ? (~idx_r + 17'd1) : idx_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [47:0] wmag;
  logic [WSUM_W-1:0] wabs;
  logic [LOG_W-1:0]  log_res;
  logic              log_busy;

  assign wabs = w_r[WSUM_W-1] ? (-w_r) : w_r;
  assign wmag = wabs[47:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      MUL_NONE:    ;
      MUL_MAG_MAG: begin mul_a = 32'(mag);     mul_b = 32'(mag); end
      MUL_CNT_P:   begin mul_a = 32'(cnt_r);   mul_b = p_r[31:0]; end
      MUL_CNT_MAG: begin mul_a = 32'(cnt_r);   mul_b = 32'(mag); end
      MUL_CNT_LOG: begin mul_a = 32'(cnt_r);   mul_b = 32'(log_res); end
      MUL_N_N:     begin mul_a = n_r;          mul_b = n_r; end
      MUL_QLO_N:   begin mul_a = q_r[31:0];    mul_b = n_r; end
      MUL_QHI_N:   begin mul_a = q_r[63:32];   mul_b = n_r; end
      MUL_WL_WL:   begin mul_a = wmag[31:0];   mul_b = wmag[31:0]; end
      MUL_WL_WH:   begin mul_a = wmag[31:0];   mul_b = 32'(wmag[47:32]); end
      MUL_WH_WH:   begin mul_a = 32'(wmag[47:32]); mul_b = 32'(wmag[47:32]); end
      MUL_ENT_T:   begin mul_a = 32'(ent_r);   mul_b = tot32; end
      default:     ;
    endcase
  end

  // log unit: bin count during a bin, total count at the end
  hes_log u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.log_start),
    .operand (cmd.log_tot ? tot32 : 32'(cnt_r)),
    .busy    (log_busy),
    .result  (log_res)
  );

  // divider operand select
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] quo;
  logic              div_busy;
  logic [56:0]       mean_num;
  logic [54:0]       ent_num;

  assign mean_num = 57'({wmag, 8'b0}) + 57'(n_r[31:1]);
  assign ent_num  = 55'(l_r) + 55'(tot32[31:1]);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (cmd.div)
      DIV_NONE: ;
      DIV_MEAN: begin div_num = DIV_NW'(mean_num);   div_den = DIV_DW'(n_r); end
      DIV_VAR:  begin div_num = {acc_r, 9'b0};       div_den = nn_r; end
      DIV_ENT:  begin div_num = DIV_NW'(ent_num);    div_den = DIV_DW'(tot32); end
      default:  ;
    endcase
  end

  hes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div != DIV_NONE),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // result shaping from the quotient
  logic             mean_sat;
  logic [23:0]      mean_mag;
  logic [39:0]      var_inc;
  logic             ent_zero;
  logic [53:0]      bits_rnd;

  assign mean_sat = |quo[DIV_NW-1:23];
  assign mean_mag = {1'b0, quo[22:0]};
  assign var_inc  = quo[39:0] + 40'd1;
  assign ent_zero = (|quo[DIV_NW-1:LOG_W]) || (quo[LOG_W-1:0] >= log_res);
  assign bits_rnd = 54'(p_r[52:0]) + 54'd32768;

  // item latch and final-phase payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r <= in_mode;
      idx_r  <= in_bin_index;
      cnt_r  <= in_bin_count[BIN_COUNT_BITS-1:0];
      last_r <= in_last_bin;
    end
    if (cmd.mul != MUL_NONE) begin
      p_r <= mul_a * mul_b;
    end
    unique case (cmd.acc)
      ACC_NONE:  ;
      ACC_CLR:   acc_r <= '0;
      ACC_ADD0:  acc_r <= acc_r + ACC_W'(p_r);
      ACC_ADD32: acc_r <= acc_r + {p_r, 32'b0};
      ACC_SUB0:  acc_r <= acc_r - ACC_W'(p_r);
      ACC_SUB33: acc_r <= acc_r - {p_r[62:0], 33'b0};
      ACC_SUB64: acc_r <= acc_r - {p_r[31:0], 64'b0};
      default:   ;
    endcase
    if (cmd.fin_n) begin
      n_r <= tot32 - 32'(pre_r);
    end
    if (cmd.nn_cap) begin
      nn_r <= p_r;
    end
    if (cmd.mean_cap) begin
      if (mean_sat) begin
        mean_r <= w_r[WSUM_W-1] ? 24'h800000 : 24'h7FFFFF;
      end else begin
        mean_r <= w_r[WSUM_W-1] ? (-mean_mag) : mean_mag;
      end
    end
    if (cmd.var_cap) begin
      var_r <= var_inc[39:1];
    end
    if (cmd.ent_cap) begin
      ent_r <= ent_zero ? '0 : (log_res - quo[LOG_W-1:0]);
    end
    if (cmd.bits_cap) begin
      bits_r <= bits_rnd[53:16];
    end
  end

  // histogram state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
      pre_r <= '0;
      w_r   <= '0;
      q_r   <= '0;
      l_r   <= '0;
      any_r <= 1'b0;
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      tot_r <= '0;
      pre_r <= '0;
      w_r   <= '0;
      q_r   <= '0;
      l_r   <= '0;
      any_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.sat) begin
        tot_r <= TMAX[TCB-1:0];
        ovf_r <= 1'b1;
      end
      if (cmd.commit) begin
        tot_r <= sum33[TCB-1:0];
        if (!mode_r && idx_r == '0) begin
          pre_r <= pre_r + sum33[TCB-1:0] - tot_r;
        end
        any_r <= 1'b1;
      end
      unique case (cmd.sum)
        SUM_NONE: ;
        SUM_Q:    q_r <= q_r + p_r;
        SUM_W:    w_r <= idx_r[IDX_W-1] ? (w_r - $signed({1'b0, p_r[47:0]}))
                                        : (w_r + $signed({1'b0, p_r[47:0]}));
        SUM_L:    l_r <= l_r + p_r[LSUM_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!any_r || $signed(idx_r) < $signed(min_r)) begin
        min_r <= idx_r;
      end
      if (!any_r || $signed(idx_r) > $signed(max_r)) begin
        max_r <= idx_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (any_r) begin
        out_min_seen <= min_r;
        out_max_seen <= max_r;
      end else if (!mode_r) begin
        out_min_seen <= {cfg_high[CFG_W-1], cfg_high};
        out_max_seen <= {cfg_low[CFG_W-1], cfg_low};
      end else begin
        out_min_seen <= {1'b0, cfg_run};
        out_max_seen <= '0;
      end
      out_symbol_count   <= n_r;
      out_mean_q8        <= (n_r == '0) ? '0 : mean_r;
      out_variance_q8    <= (n_r == '0) ? '0 : var_r;
      out_entropy_q16    <= (n_r == '0) ? '0 : ENT_W'(ent_r);
      out_total_bits     <= (n_r == '0) ? '0 : bits_r;
      out_count_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts          = '0;
    sts.ok       = (cnt_r != '0) && (mode_r ? ok_run : ok_val);
    sts.sat      = (sum33 > TMAX);
    sts.last     = last_r;
    sts.n_zero   = (n_r == '0);
    sts.log_busy = log_busy;
    sts.div_busy = div_busy;
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

@@ src/hes_ctrl.sv @@
// ----------------------------------------------------------------------------
// hes_ctrl: histogram statistics sequencer
// Steps one bin through the shared multiplier, then runs the final phase.
// ----------------------------------------------------------------------------
module hes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hes_pkg::hes_sts_t sts,
  output hes_pkg::hes_cmd_t cmd
);
  import hes_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_F5,
    ST_F6,
    ST_F7,
    ST_F8,
    ST_F9,
    ST_F10,
    ST_F11,
    ST_F12,
    ST_LOAD
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.ok && !sts.sat) begin
          cmd.commit    = 1'b1;
          cmd.mul       = MUL_MAG_MAG;
          cmd.log_start = 1'b1;
          state_nxt     = ST_B1;
        end else begin
          cmd.sat   = sts.ok;
          state_nxt = sts.last ? ST_F0 : ST_IDLE;
        end
      end
      ST_B1: begin
        cmd.mul   = MUL_CNT_P;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        cmd.mul   = MUL_CNT_MAG;
        cmd.sum   = SUM_Q;
        state_nxt = ST_B3;
      end
      ST_B3: begin
        if (!sts.log_busy) begin
          cmd.mul   = MUL_CNT_LOG;
          cmd.sum   = SUM_W;
          state_nxt = ST_B4;
        end
      end
      ST_B4: begin
        cmd.sum   = SUM_L;
        state_nxt = sts.last ? ST_F0 : ST_IDLE;
      end
      ST_F0: begin
        cmd.fin_n = 1'b1;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        if (sts.n_zero) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.log_start = 1'b1;
          cmd.log_tot   = 1'b1;
          cmd.div       = DIV_MEAN;
          cmd.mul       = MUL_N_N;
          cmd.acc       = ACC_CLR;
          state_nxt     = ST_F2;
        end
      end
      ST_F2: begin
        cmd.nn_cap = 1'b1;
        cmd.mul    = MUL_QLO_N;
        state_nxt  = ST_F3;
      end
      ST_F3: begin
        cmd.mul   = MUL_QHI_N;
        cmd.acc   = ACC_ADD0;
        state_nxt = ST_F4;
      end
      ST_F4: begin
        cmd.mul   = MUL_WL_WL;
        cmd.acc   = ACC_ADD32;
        state_nxt = ST_F5;
      end
      ST_F5: begin
        cmd.mul   = MUL_WL_WH;
        cmd.acc   = ACC_SUB0;
        state_nxt = ST_F6;
      end
      ST_F6: begin
        cmd.mul   = MUL_WH_WH;
        cmd.acc   = ACC_SUB33;
        state_nxt = ST_F7;
      end
      ST_F7: begin
        cmd.acc   = ACC_SUB64;
        state_nxt = ST_F8;
      end
      ST_F8: begin
        if (!sts.div_busy) begin
          cmd.mean_cap = 1'b1;
          cmd.div      = DIV_VAR;
          state_nxt    = ST_F9;
        end
      end
      ST_F9: begin
        if (!sts.div_busy) begin
          cmd.var_cap = 1'b1;
          cmd.div     = DIV_ENT;
          state_nxt   = ST_F10;
        end
      end
      ST_F10: begin
        if (!sts.div_busy && !sts.log_busy) begin
          cmd.ent_cap = 1'b1;
          state_nxt   = ST_F11;
        end
      end
      ST_F11: begin
        cmd.mul   = MUL_ENT_T;
        state_nxt = ST_F12;
      end
      ST_F12: begin
        cmd.bits_cap = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/histogram_entropy_stats.sv @@
// ----------------------------------------------------------------------------
// histogram_entropy_stats: histogram statistics with Shannon entropy
// Min, max, symbol count, mean, variance, entropy and total bits per histogram.
// ----------------------------------------------------------------------------
// Bins arrive one per transfer on in_ch as (mode, bin_index, bin_count,
// last_bin); the transfer with last_bin set closes the histogram and one
// result transfer follows on out_ch. The block works on one bin at a time.
// A bin that is out of range, has a zero count or saturates the total count
// is dropped in the check state. An accepted bin goes through the shared
// multiplier while the log2 unit normalizes one bit per cycle and then runs
// 16 squarings on its own multiplier, and that loop sets the time a bin takes.
// Closing a histogram, once the output register is free, is set by three
// passes of the 105-step serial divider (mean, variance, entropy); an empty
// histogram or one with only prefix counts skips them. The result sits in an
// output register, so the next bin is taken while the previous result waits;
// a further closing bin waits for that register to free up. Configuration is
// written over the APB port (value_range_low at 0x0, value_range_high at 0x4,
// max_run_length at 0x8); the user must write it only while no histogram is
// in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module histogram_entropy_stats #(
  parameter int VALUE_BITS       = hes_pkg::HES_VALUE_BITS,
  parameter int BIN_COUNT_BITS   = hes_pkg::HES_BIN_COUNT_BITS,
  parameter int TOTAL_COUNT_BITS = hes_pkg::HES_TOTAL_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  hes_in_if.sink      in_ch,
  hes_out_if.source   out_ch
);
  import hes_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] cfg_low_r, cfg_high_r, cfg_run_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_low_r  <= 16'h8000;
      cfg_high_r <= 16'h7FFF;
      cfg_run_r  <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_VALUE_LOW:  cfg_low_r  <= cfg_pwdata[CFG_W-1:0];
        REG_VALUE_HIGH: cfg_high_r <= cfg_pwdata[CFG_W-1:0];
        REG_MAX_RUN:    cfg_run_r  <= cfg_pwdata[CFG_W-1:0];
        default:        ;   // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_VALUE_LOW:  cfg_prdata = 32'(cfg_low_r);
      REG_VALUE_HIGH: cfg_prdata = 32'(cfg_high_r);
      REG_MAX_RUN:    cfg_prdata = 32'(cfg_run_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // controller / datapath
  hes_cmd_t cmd;
  hes_sts_t sts;

  hes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hes_dp #(
    .VALUE_BITS       (VALUE_BITS),
    .BIN_COUNT_BITS   (BIN_COUNT_BITS),
    .TOTAL_COUNT_BITS (TOTAL_COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_low            (cfg_low_r),
    .cfg_high           (cfg_high_r),
    .cfg_run            (cfg_run_r),
    .in_mode            (in_ch.mode),
    .in_bin_index       (in_ch.bin_index),
    .in_bin_count       (in_ch.bin_count),
    .in_last_bin        (in_ch.last_bin),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_min_seen       (out_ch.min_seen),
    .out_max_seen       (out_ch.max_seen),
    .out_symbol_count   (out_ch.symbol_count),
    .out_mean_q8        (out_ch.mean_q8),
    .out_variance_q8    (out_ch.variance_q8),
    .out_entropy_q16    (out_ch.entropy_q16),
    .out_total_bits     (out_ch.total_bits),
    .out_count_overflow (out_ch.count_overflow)
  );

  // after a bin transfer the bin channel is not ready in the next cycle
  a_busy_after_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("bin channel ready right after a bin transfer");

  // with no symbols mean, variance, entropy and total bits read zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.symbol_count == '0) |->
      (out_ch.mean_q8 == '0 && out_ch.variance_q8 == '0 &&
       out_ch.entropy_q16 == '0 && out_ch.total_bits == '0))
    else $error("nonzero statistic with zero symbol count");

  // entropy stays below 32 bits per symbol
  a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entropy_q16 < 22'd2097152))
    else $error("entropy out of range");

endmodule

@@ tb/tb_histogram_entropy_stats.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_entropy_stats: self-checking bench for histogram_entropy_stats
// Feeds directed and random histograms under random idling on both channels,
// writes the range registers over APB between phases, and checks every
// result transfer field by field against a built-in fixed-point predictor or a typed row.
// ----------------------------------------------------------------------------
module tb_histogram_entropy_stats;
  import hes_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;   // margin after the last result before the end
  localparam int RANDOM_ITEMS   = 1600;

  typedef struct packed {
    logic [IDX_W-1:0]  min_seen;
    logic [IDX_W-1:0]  max_seen;
    logic [SYM_W-1:0]  symbol_count;
    logic [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]  variance_q8;
    logic [ENT_W-1:0]  entropy_q16;
    logic [BITS_W-1:0] total_bits;
    logic              count_overflow;
  } hist_result_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic             typed;   // expectation written in the row
    hist_result_t     res;
  } bin_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  hes_in_if  in_ch ();
  hes_out_if out_ch ();

  histogram_entropy_stats i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the registers and the running histogram sums
  // --------------------------------------------------------------------------
  int          range_low, range_high, run_limit;
  logic [63:0] sum_count, sum_prefix, sum_square, sum_log;
  longint      sum_weighted;
  int          idx_lo, idx_hi;
  bit          any_bin, sat_seen;

  hist_result_t results_pending[$];
  int           fail_count;
  int           items_sent;
  int           idle_cycles;
  bit           sender_calm;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // log2 in Q16: integer part from the top set bit, fraction by squaring a
  // Q30 mantissa sixteen times, truncating each square
  function automatic logic [63:0] log2_fixed(input logic [31:0] n);
    int          e;
    logic [63:0] m, frac;
    frac = 0;
    if (n == 0) return 0;
    e = 31;
    while (!n[e]) e--;
    m = (e > 30) ? (64'(n) >> (e - 30)) : (64'(n) << (30 - e));
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic void clear_histogram();
    sum_count = 0; sum_prefix = 0; sum_weighted = 0; sum_square = 0; sum_log = 0;
    idx_lo = 0; idx_hi = 0; any_bin = 0; sat_seen = 0;
  endfunction

  // absorb one bin; on the closing bin return the statistics
  function automatic bit absorb_bin(input logic mode, input logic [IDX_W-1:0] idx_raw,
                                    input logic [CNT_W-1:0] cnt, input logic last,
                                    output hist_result_t r);
    int           idx;
    bit           ok;
    logic [63:0]  mag, n, t, wmag, q, lt, sq, ent, bits, spread, lo64, hi64;
    logic [127:0] d;
    longint       mean;
    idx = int'($signed(idx_raw));
    ok  = 0;
    r   = '0;
    if (cnt != 0) begin
      if (mode == 1'b0) ok = (idx >= range_low) && (idx <= range_high);
      else              ok = (idx >= 1) && (idx <= run_limit);
    end
    if (ok) begin
      if (sum_count + 64'(cnt) > 64'hFFFF_FFFF) begin
        sum_count = 64'hFFFF_FFFF;   // saturated bin is dropped
        sat_seen  = 1;
      end else begin
        mag = (idx < 0) ? 64'(-idx) : 64'(idx);
        sum_count += 64'(cnt);
        if (mode == 1'b0 && idx == 0) sum_prefix += 64'(cnt);
        sum_weighted += longint'(cnt) * longint'(idx);
        sum_square   += 64'(cnt) * (mag * mag);
        sum_log      += 64'(cnt) * log2_fixed(32'(cnt));
        if (!any_bin || idx < idx_lo) idx_lo = idx;
        if (!any_bin || idx > idx_hi) idx_hi = idx;
        any_bin = 1;
      end
    end
    if (!last) return 0;

    if (any_bin) begin
      r.min_seen = IDX_W'(idx_lo); r.max_seen = IDX_W'(idx_hi);
    end else if (mode == 1'b0) begin
      r.min_seen = IDX_W'(range_high); r.max_seen = IDX_W'(range_low);
    end else begin
      r.min_seen = IDX_W'(run_limit); r.max_seen = '0;
    end
    n = sum_count - sum_prefix;
    t = sum_count;
    r.symbol_count = SYM_W'(n);
    if (n != 0) begin
      wmag = (sum_weighted < 0) ? 64'(-sum_weighted) : 64'(sum_weighted);
      q = (wmag * 256 + n / 2) / n;
      if (q > 64'd8388607) q = (sum_weighted < 0) ? 64'd8388608 : 64'd8388607;
      mean = (sum_weighted < 0) ? -longint'(q) : longint'(q);
      r.mean_q8 = MEAN_W'(mean);

      d = 128'(sum_square) * 128'(n) - 128'(wmag) * 128'(wmag);
      d = d << 9;
      d = (d / 128'(n)) / 128'(n);
      lo64 = d[63:0]; hi64 = d[127:64];
      spread = ((lo64 + 64'd1) >> 1) | (hi64 << 63);
      r.variance_q8 = VAR_W'(spread);

      lt  = log2_fixed(t[31:0]);
      sq  = (sum_log + t / 2) / t;
      ent = (sq >= lt) ? 64'd0 : lt - sq;
      if (ent > 64'h3F_FFFF) ent = 64'h3F_FFFF;
      bits = (ent * t + 64'd32768) >> 16;
      r.entropy_q16 = ENT_W'(ent);
      r.total_bits  = BITS_W'(bits);
    end
    r.count_overflow = sat_seen;
    clear_histogram();
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // Bin sender: random gap, then hold valid until the transfer happens
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    if (sender_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_bin(input logic mode, input logic [IDX_W-1:0] idx,
                          input logic [CNT_W-1:0] cnt, input logic last,
                          input bit typed, input hist_result_t typed_res);
    int           gap;
    hist_result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.bin_index <= idx;
    in_ch.bin_count <= cnt;
    in_ch.last_bin  <= last;
    do @(posedge clk); while (!in_ch.ready);
    // transfer done at this edge
    items_sent++;
    if (absorb_bin(mode, idx, cnt, last, r))
      results_pending.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
    // a trailing bin without a result may still be in the log unit
    repeat (100) @(posedge clk);
  endtask

  // two-phase APB write; the register takes the value at the access edge
  task automatic write_reg(input cfg_reg_t which, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(which) << 2;
    cfg_pwdata  <= {16'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (which)
      REG_VALUE_LOW:  range_low  = int'($signed(value));
      REG_VALUE_HIGH: range_high = int'($signed(value));
      REG_MAX_RUN:    run_limit  = int'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ranges(input int lo, input int hi, input int run);
    wait_drained();
    write_reg(REG_VALUE_LOW, 16'(lo));
    write_reg(REG_VALUE_HIGH, 16'(hi));
    write_reg(REG_MAX_RUN, 16'(run));
  endtask

  // --------------------------------------------------------------------------
  // Random histograms: mostly well-formed bins inside the configured range
  // --------------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return CNT_W'($urandom_range(1, 15));
    if (roll < 70) return CNT_W'($urandom_range(1, 4095));
    if (roll < 90) return CNT_W'($urandom);
    return (roll < 95) ? '0 : '1;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input logic mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= 85) return IDX_W'($urandom);
    if (roll < 8) return '0;   // prefix bin in value mode
    if (mode == 1'b0) begin
      if (range_low > range_high) return IDX_W'($urandom);
      return IDX_W'(range_low + int'($urandom_range(0, range_high - range_low)));
    end
    return IDX_W'($urandom_range(1, run_limit));
  endfunction

  task automatic random_histogram();
    int   nbins;
    logic mode, bin_mode;
    nbins = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    mode  = 1'($urandom);
    sender_calm = ($urandom_range(0, 5) == 0);
    for (int b = 0; b < nbins; b++) begin
      bin_mode = ($urandom_range(0, 9) == 0) ? ~mode : mode;
      send_bin(bin_mode, pick_index(bin_mode), pick_count(), b == nbins - 1, 0, '0);
    end
  endtask

  // enough full bins to run the total count into saturation
  task automatic saturating_histogram();
    sender_calm = 1;
    for (int b = 0; b < 262; b++)
      send_bin(1'b0, IDX_W'($urandom_range(1, 200)), '1, b == 261, 0, '0);
    sender_calm = 0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table, default ranges. Expectations typed only for the obvious
  // rows: empty histograms, a lone bin and a prefix-only histogram.
  // --------------------------------------------------------------------------
  localparam hist_result_t EMPTY_VALUE = '{min_seen: 17'h07FFF, max_seen: 17'h18000,
                                           default: '0};
  localparam hist_result_t EMPTY_RUN   = '{min_seen: 17'h0FFFF, default: '0};
  localparam hist_result_t LONE_FIVE   = '{min_seen: 17'd5, max_seen: 17'd5,
                                           symbol_count: 32'd1, mean_q8: 24'd1280,
                                           default: '0};
  localparam hist_result_t ONLY_PREFIX = '0;

  localparam int DIRECTED_ROWS = 17;
  localparam bin_row_t directed_rows[DIRECTED_ROWS] = '{
    '{1'b0, 17'h00000, 24'h000000, 1'b1, 1'b1, EMPTY_VALUE},  // empty, value mode
    '{1'b1, 17'h00000, 24'h000005, 1'b1, 1'b1, EMPTY_RUN},    // run 0 never taken
    '{1'b0, 17'h00005, 24'h000001, 1'b1, 1'b1, LONE_FIVE},
    '{1'b0, 17'h18000, 24'hFFFFFF, 1'b0, 1'b0, '0},           // lowest value
    '{1'b0, 17'h07FFF, 24'hFFFFFF, 1'b0, 1'b0, '0},           // highest value
    '{1'b0, 17'h00000, 24'h0003E8, 1'b0, 1'b0, '0},           // run prefix
    '{1'b0, 17'h0FFFF, 24'h000003, 1'b0, 1'b0, '0},           // above value range
    '{1'b0, 17'h00001, 24'h000000, 1'b1, 1'b0, '0},           // zero count closes
    '{1'b1, 17'h00001, 24'hFFFFFF, 1'b0, 1'b0, '0},
    '{1'b1, 17'h0FFFF, 24'h800000, 1'b0, 1'b0, '0},           // longest run
    '{1'b1, 17'h1FFFF, 24'h000007, 1'b0, 1'b0, '0},           // negative run ignored
    '{1'b1, 17'h10000, 24'h000002, 1'b1, 1'b0, '0},
    '{1'b0, 17'h00000, 24'h0001F4, 1'b1, 1'b1, ONLY_PREFIX},  // no symbols
    '{1'b0, 17'h05555, 24'hAAAAAA, 1'b0, 1'b0, '0},
    '{1'b0, 17'h1AAAA, 24'h555555, 1'b0, 1'b0, '0},
    '{1'b1, 17'h02AAA, 24'h000001, 1'b0, 1'b0, '0},           // modes mixed
    '{1'b0, 17'h1FFFF, 24'h000002, 1'b1, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field check
  // --------------------------------------------------------------------------
  int stall_left;
  int calm_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      calm_left    <= 0;
    end else if (calm_left > 0) begin
      out_ch.ready <= 1'b1;
      calm_left    <= calm_left - 1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 19))
        0:       stall_left <= $urandom_range(20, 100);
        1:       calm_left  <= $urandom_range(200, 2000);
        2, 3, 4: stall_left <= $urandom_range(1, 3);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_pending.size() == 0) begin
        report("unexpected result, symbol_count", 64'(out_ch.symbol_count), 64'd0);
      end else begin
        want = results_pending.pop_front();
        if (out_ch.min_seen !== want.min_seen)
          report("min_seen", 64'(out_ch.min_seen), 64'(want.min_seen));
        if (out_ch.max_seen !== want.max_seen)
          report("max_seen", 64'(out_ch.max_seen), 64'(want.max_seen));
        if (out_ch.symbol_count !== want.symbol_count)
          report("symbol_count", 64'(out_ch.symbol_count), 64'(want.symbol_count));
        if (out_ch.mean_q8 !== want.mean_q8)
          report("mean_q8", 64'(out_ch.mean_q8), 64'(want.mean_q8));
        if (out_ch.variance_q8 !== want.variance_q8)
          report("variance_q8", 64'(out_ch.variance_q8), 64'(want.variance_q8));
        if (out_ch.entropy_q16 !== want.entropy_q16)
          report("entropy_q16", 64'(out_ch.entropy_q16), 64'(want.entropy_q16));
        if (out_ch.total_bits !== want.total_bits)
          report("total_bits", 64'(out_ch.total_bits), 64'(want.total_bits));
        if (out_ch.count_overflow !== want.count_overflow)
          report("count_overflow", 64'(out_ch.count_overflow), 64'(want.count_overflow));
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_target;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.bin_index <= '0;
    in_ch.bin_count <= '0;
    in_ch.last_bin  <= 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    idle_cycles = 0;
    sender_calm = 0;
    range_low   = -32768;
    range_high  = 32767;
    run_limit   = 65535;
    clear_histogram();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_bin(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].cnt,
               directed_rows[i].last, directed_rows[i].typed, directed_rows[i].res);

    // phases of ranges: narrow, the inverted extremes, a single value, then back to full width
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_ranges(-100, 100, 16);
        1: set_ranges(32767, -32768, 1);
        2: set_ranges(-32768, -32768, 65535);
        default: set_ranges(-32768, 32767, 65535);
      endcase
      if (phase == 3) saturating_histogram();
      phase_target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_target) begin
        random_histogram();
        // now and then hold the sender until every result is in
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
    end

    in_ch.valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
